### design/polygon_area_rank_core_assert.svh
// Assertion macros shared by the polygon area rank modules.
`ifndef POLYGON_AREA_RANK_CORE_ASSERT_SVH
`define POLYGON_AREA_RANK_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define POLYAR_ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("polygon area rank: assertion failed");
`define POLYAR_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("polygon area rank: assertion failed");
`else
`define POLYAR_ASSERT_IMP(label, clk, rst, pre, post)
`define POLYAR_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

### design/polyar_pkg.sv
`timescale 1ns / 1ps
package polyar_pkg;

  localparam int MAX_POLYGONS  = 64;
  localparam int COORD_BITS    = 24;
  localparam int IN_COORD_BITS = 24;
  localparam int AREA_BITS     = 52;
  localparam int IDX_BITS      = 6;
  localparam int ACC_BITS      = 64;
  localparam int ADDR_BITS     = (MAX_POLYGONS > 1) ? $clog2(MAX_POLYGONS) : 1;
  localparam int CNT_BITS      = $clog2(MAX_POLYGONS + 1);
  localparam int DIFF_BITS     = COORD_BITS + 1;
  localparam int PROD_BITS     = 2 * DIFF_BITS;
  localparam int TERM_BITS     = PROD_BITS + 1;

  localparam logic [AREA_BITS-1:0] AREA_MAX = {AREA_BITS{1'b1}};

  typedef struct packed {
    logic load;
    logic mul;
    logic acc;
    logic close;
    logic rd_i;
    logic lat_i;
    logic rd_j;
    logic cmp_j;
    logic next_i;
    logic finish;
  } polyar_cmd_t;

  typedef struct packed {
    logic poly_end;
    logic set_end;
    logic i_last;
    logic j_last;
  } polyar_stat_t;

endpackage

### design/polyar_if.sv
`timescale 1ns / 1ps
interface polyar_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [polyar_pkg::IN_COORD_BITS-1:0]    x_coord;
  logic [polyar_pkg::IN_COORD_BITS-1:0]    y_coord;
  logic                                    end_of_polygon;
  logic                                    end_of_set;

  modport source (output valid, x_coord, y_coord, end_of_polygon, end_of_set,
                  input ready);
  modport sink (input valid, x_coord, y_coord, end_of_polygon, end_of_set,
                output ready);
endinterface

interface polyar_out_if;
  logic                              valid;
  logic                              ready;
  logic [polyar_pkg::IDX_BITS-1:0]   polygon_index;
  logic [polyar_pkg::IDX_BITS-1:0]   area_rank;
  logic [polyar_pkg::AREA_BITS-1:0]  twice_area;
  logic                              dropped;
  logic                              last_result;

  modport source (output valid, polygon_index, area_rank, twice_area, dropped,
                  last_result, input ready);
  modport sink (input valid, polygon_index, area_rank, twice_area, dropped,
                last_result, output ready);
endinterface

### design/polyar_ctrl.sv
`timescale 1ns / 1ps
`include "polygon_area_rank_core_assert.svh"
module polyar_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  logic                     out_ready,
  input  polyar_pkg::polyar_stat_t stat,
  output polyar_pkg::polyar_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_CLOSE,
    S_RD_I,
    S_LAT_I,
    S_RD_J,
    S_CMP_J,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   in_acc;
  logic   out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = (stat.poly_end || stat.set_end) ? S_CLOSE : S_IDLE;
      end
      S_CLOSE: begin
        cmd.close  = 1'b1;
        state_next = stat.set_end ? S_RD_I : S_IDLE;
      end
      S_RD_I: begin
        cmd.rd_i   = 1'b1;
        state_next = S_LAT_I;
      end
      S_LAT_I: begin
        cmd.lat_i  = 1'b1;
        state_next = S_RD_J;
      end
      S_RD_J: begin
        cmd.rd_j   = 1'b1;
        state_next = S_CMP_J;
      end
      S_CMP_J: begin
        cmd.cmp_j  = 1'b1;
        state_next = stat.j_last ? S_EMIT : S_RD_J;
      end
      S_EMIT: begin
        if (out_acc) begin
          if (stat.i_last) begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.next_i = 1'b1;
            state_next = S_RD_I;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      in_ready  <= (state_next == S_IDLE);
      out_valid <= (state_next == S_EMIT);
    end
  end

  `POLYAR_ASSERT_IMP(a_out_blocks_in, clk, rst, out_valid, !in_ready)
  `POLYAR_ASSERT_NEXT(a_busy_after_item, clk, rst, in_valid && in_ready, !in_ready)
  `POLYAR_ASSERT_NEXT(a_idle_after_set, clk, rst, out_acc && stat.i_last, in_ready && !out_valid)

endmodule

### design/polyar_datapath.sv
`timescale 1ns / 1ps
`include "polygon_area_rank_core_assert.svh"
module polyar_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  polyar_pkg::polyar_cmd_t              cmd,
  output polyar_pkg::polyar_stat_t             stat,
  input  logic [polyar_pkg::IN_COORD_BITS-1:0] x_coord,
  input  logic [polyar_pkg::IN_COORD_BITS-1:0] y_coord,
  input  logic                                 end_of_polygon,
  input  logic                                 end_of_set,
  output logic [polyar_pkg::IDX_BITS-1:0]      polygon_index,
  output logic [polyar_pkg::IDX_BITS-1:0]      area_rank,
  output logic [polyar_pkg::AREA_BITS-1:0]     twice_area,
  output logic                                 dropped,
  output logic                                 last_result
);

  logic signed [polyar_pkg::COORD_BITS-1:0] x_in;
  logic signed [polyar_pkg::COORD_BITS-1:0] y_in;
  logic signed [polyar_pkg::COORD_BITS-1:0] first_x;
  logic signed [polyar_pkg::COORD_BITS-1:0] first_y;
  logic signed [polyar_pkg::COORD_BITS-1:0] prev_x;
  logic signed [polyar_pkg::COORD_BITS-1:0] prev_y;
  logic [1:0]                               vertex_seen;
  logic                                     term_en;
  logic                                     poly_end;
  logic                                     set_end;
  logic signed [polyar_pkg::DIFF_BITS-1:0]  bx;
  logic signed [polyar_pkg::DIFF_BITS-1:0]  by;
  logic signed [polyar_pkg::DIFF_BITS-1:0]  ax;
  logic signed [polyar_pkg::DIFF_BITS-1:0]  ay;
  logic signed [polyar_pkg::PROD_BITS-1:0]  prod_a;
  logic signed [polyar_pkg::PROD_BITS-1:0]  prod_b;
  logic signed [polyar_pkg::TERM_BITS-1:0]  term;
  logic signed [polyar_pkg::ACC_BITS:0]     sum_wide;
  logic signed [polyar_pkg::ACC_BITS-1:0]   sum_sat;
  logic signed [polyar_pkg::ACC_BITS-1:0]   area_sum;
  logic [polyar_pkg::ACC_BITS-1:0]          mag;
  logic [polyar_pkg::AREA_BITS-1:0]         area_clip;
  logic [polyar_pkg::CNT_BITS-1:0]          count;
  logic                                     overflow;
  logic                                     room;
  logic [polyar_pkg::CNT_BITS-1:0]          i;
  logic [polyar_pkg::CNT_BITS-1:0]          j;
  logic [polyar_pkg::CNT_BITS-1:0]          rank;
  logic [polyar_pkg::CNT_BITS-1:0]          raddr;
  logic [polyar_pkg::AREA_BITS-1:0]         ai;
  logic [polyar_pkg::AREA_BITS-1:0]         rdata;
  logic                                     ahead;
  logic [polyar_pkg::AREA_BITS-1:0]         mem [polyar_pkg::MAX_POLYGONS];

  assign x_in = $signed(x_coord[polyar_pkg::COORD_BITS-1:0]);
  assign y_in = $signed(y_coord[polyar_pkg::COORD_BITS-1:0]);

  // Fan-triangle cross product, then a saturating add into the 64-bit sum.
  assign term     = polyar_pkg::TERM_BITS'(prod_a) - polyar_pkg::TERM_BITS'(prod_b);
  assign sum_wide = (polyar_pkg::ACC_BITS + 1)'(area_sum)
                  + (polyar_pkg::ACC_BITS + 1)'(term);

  always_comb begin
    if (sum_wide[polyar_pkg::ACC_BITS] == sum_wide[polyar_pkg::ACC_BITS-1]) begin
      sum_sat = sum_wide[polyar_pkg::ACC_BITS-1:0];
    end else if (sum_wide[polyar_pkg::ACC_BITS]) begin
      sum_sat = {1'b1, {(polyar_pkg::ACC_BITS-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(polyar_pkg::ACC_BITS-1){1'b1}}};
    end
  end

  // The most negative sum negates to 2^63, which clips like any large value.
  assign mag = area_sum[polyar_pkg::ACC_BITS-1]
             ? (~area_sum + polyar_pkg::ACC_BITS'(1)) : area_sum;
  assign area_clip = (mag > polyar_pkg::ACC_BITS'(polyar_pkg::AREA_MAX))
                   ? polyar_pkg::AREA_MAX : mag[polyar_pkg::AREA_BITS-1:0];

  assign room  = (count < polyar_pkg::CNT_BITS'(polyar_pkg::MAX_POLYGONS));
  assign raddr = cmd.rd_i ? i : j;
  assign ahead = (rdata > ai) || ((rdata == ai) && (j < i));

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_seen <= '0;
      area_sum    <= '0;
      count       <= '0;
      overflow    <= 1'b0;
      i           <= '0;
      term_en     <= 1'b0;
      poly_end    <= 1'b0;
      set_end     <= 1'b0;
    end else begin
      if (cmd.load) begin
        bx       <= polyar_pkg::DIFF_BITS'(x_in) - polyar_pkg::DIFF_BITS'(first_x);
        by       <= polyar_pkg::DIFF_BITS'(y_in) - polyar_pkg::DIFF_BITS'(first_y);
        ax       <= polyar_pkg::DIFF_BITS'(prev_x) - polyar_pkg::DIFF_BITS'(first_x);
        ay       <= polyar_pkg::DIFF_BITS'(prev_y) - polyar_pkg::DIFF_BITS'(first_y);
        term_en  <= vertex_seen[1];
        poly_end <= end_of_polygon;
        set_end  <= end_of_set;
        prev_x   <= x_in;
        prev_y   <= y_in;
        if (vertex_seen == 2'd0) begin
          first_x     <= x_in;
          first_y     <= y_in;
          vertex_seen <= 2'd1;
        end else begin
          vertex_seen <= 2'd2;
        end
      end
      if (cmd.mul) begin
        prod_a <= bx * ay;
        prod_b <= by * ax;
      end
      if (cmd.acc && term_en) begin
        area_sum <= sum_sat;
      end
      if (cmd.close) begin
        if (room) begin
          count <= count + polyar_pkg::CNT_BITS'(1);
        end else begin
          overflow <= 1'b1;
        end
        area_sum    <= '0;
        vertex_seen <= 2'd0;
      end
      if (cmd.lat_i) begin
        ai   <= rdata;
        j    <= '0;
        rank <= '0;
      end
      if (cmd.cmp_j) begin
        j <= j + polyar_pkg::CNT_BITS'(1);
        if (ahead) begin
          rank <= rank + polyar_pkg::CNT_BITS'(1);
        end
      end
      if (cmd.next_i) begin
        i <= i + polyar_pkg::CNT_BITS'(1);
      end
      if (cmd.finish) begin
        i        <= '0;
        count    <= '0;
        overflow <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.close && room) begin
      mem[count[polyar_pkg::ADDR_BITS-1:0]] <= area_clip;
    end
    if (cmd.rd_i || cmd.rd_j) begin
      rdata <= mem[raddr[polyar_pkg::ADDR_BITS-1:0]];
    end
  end

  assign stat.poly_end = poly_end;
  assign stat.set_end  = set_end;
  assign stat.i_last   = ((i + polyar_pkg::CNT_BITS'(1)) == count);
  assign stat.j_last   = ((j + polyar_pkg::CNT_BITS'(1)) == count);

  assign polygon_index = polyar_pkg::IDX_BITS'(i);
  assign area_rank     = polyar_pkg::IDX_BITS'(rank);
  assign twice_area    = ai;
  assign dropped       = overflow;
  assign last_result   = stat.i_last;

  `POLYAR_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= polyar_pkg::CNT_BITS'(polyar_pkg::MAX_POLYGONS))
  `POLYAR_ASSERT_NEXT(a_set_cleared, clk, rst, cmd.finish, (count == '0) && !overflow && (i == '0))
  `POLYAR_ASSERT_IMP(a_scan_in_range, clk, rst, cmd.cmp_j, (j < count) && (i < count))

endmodule

### design/polygon_area_rank_core.sv
`timescale 1ns / 1ps
// Channel   Role     Payload
// vertex    sink     x_coord, y_coord, end_of_polygon, end_of_set
// result    source   polygon_index, area_rank, twice_area, dropped, last_result
//
// A vertex takes load, multiply and accumulate steps; a polygon's last vertex adds
// a close step that stores its area if there is room. After a set's last polygon,
// each stored polygon is read and latched, then compared with every stored area in
// turn before its result is offered, since the single read port of the area store
// is walked once per compare. No vertex is taken until the last result is taken.
// Reset is synchronous and needs no clearing pass; a stalled result holds its value.
module polygon_area_rank_core (
  input logic         clk,
  input logic         rst,
  polyar_in_if.sink   vertex,
  polyar_out_if.source result
);

  polyar_pkg::polyar_cmd_t  cmd;
  polyar_pkg::polyar_stat_t stat;

  polyar_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vertex.valid),
    .in_ready  (vertex.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  polyar_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .x_coord        (vertex.x_coord),
    .y_coord        (vertex.y_coord),
    .end_of_polygon (vertex.end_of_polygon),
    .end_of_set     (vertex.end_of_set),
    .polygon_index  (result.polygon_index),
    .area_rank      (result.area_rank),
    .twice_area     (result.twice_area),
    .dropped        (result.dropped),
    .last_result    (result.last_result)
  );

endmodule
